[hw/rtl/ppgs_pkg.sv]
// Shared types and constants for the platform power-good sequencer.
// No dependencies; imported by every module of the block.
package ppgs_pkg;

  localparam int unsigned DELAY_W     = 8;
  localparam int unsigned CFG_INDEX_W = 4;

  localparam logic [DELAY_W-1:0] FIRST_GOOD_DELAY_RST = DELAY_W'(2);
  localparam logic [DELAY_W-1:0] SECOND_OK_DELAY_RST  = DELAY_W'(2);
  localparam logic [DELAY_W-1:0] SYSTEM_OK_DELAY_RST  = DELAY_W'(45);
  localparam logic [DELAY_W-1:0] READY_TIMEOUT_RST    = DELAY_W'(50);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_GOOD_DELAY = CFG_INDEX_W'(0),
    REG_SECOND_OK_DELAY  = CFG_INDEX_W'(1),
    REG_SYSTEM_OK_DELAY  = CFG_INDEX_W'(2),
    REG_READY_TIMEOUT    = CFG_INDEX_W'(3)
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CORE  = 3'd1,
    PH_READY = 3'd2,
    PH_HUB   = 3'd3,
    PH_SYS   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_TIMEOUT    = 2'd1,
    EV_POWER_LOST = 2'd2
  } event_t;

  typedef struct packed {
    logic [DELAY_W-1:0] first_good_delay;
    logic [DELAY_W-1:0] second_ok_delay;
    logic [DELAY_W-1:0] system_ok_delay;
    logic [DELAY_W-1:0] ready_timeout;
  } cfg_t;

  typedef struct packed {
    logic   core_good;
    logic   hub_ok;
    logic   system_ok;
    event_t shutdown;
  } result_t;

endpackage

[hw/rtl/ppgs_cfg_regs.sv]
// Configuration register file: four delay/timeout registers.
// Depends on ppgs_pkg.
module ppgs_cfg_regs
  import ppgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_good_delay <= FIRST_GOOD_DELAY_RST;
      cfg.second_ok_delay  <= SECOND_OK_DELAY_RST;
      cfg.system_ok_delay  <= SYSTEM_OK_DELAY_RST;
      cfg.ready_timeout    <= READY_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // out-of-range indexes are dropped
      unique case (cfg_index)
        REG_FIRST_GOOD_DELAY: cfg.first_good_delay <= cfg_data;
        REG_SECOND_OK_DELAY:  cfg.second_ok_delay  <= cfg_data;
        REG_SYSTEM_OK_DELAY:  cfg.system_ok_delay  <= cfg_data;
        REG_READY_TIMEOUT:    cfg.ready_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/ppgs_core.sv]
// Sequencer state (phase, delay counter, output levels) and the per-tick
// update that may pass through several zero-delay stages. Depends on ppgs_pkg.
module ppgs_core
  import ppgs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    pg,
  input  logic    rdy,
  input  cfg_t    cfg,
  output result_t result
);

  typedef struct packed {
    phase_t             ph;
    logic [DELAY_W-1:0] cnt;
  } stage_t;

  phase_t             phase, phase_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;
  logic               core_good, core_good_next;
  logic               hub_ok, hub_ok_next;
  logic               system_ok, system_ok_next;
  event_t             ev_next;

  // first stage whose output is still low
  function automatic stage_t pick_stage(input logic c, input logic h, input logic s,
                                        input cfg_t k);
    stage_t st;
    if (!c) begin
      st.ph  = PH_CORE;
      st.cnt = k.first_good_delay;
    end else if (!h) begin
      st.ph  = PH_READY;
      st.cnt = k.ready_timeout;
    end else if (!s) begin
      st.ph  = PH_SYS;
      st.cnt = k.system_ok_delay;
    end else begin
      st.ph  = PH_IDLE;
      st.cnt = '0;
    end
    return st;
  endfunction

  // Stages only move forward within one tick, so one pass in stage order
  // covers every chain of zero delays.
  always_comb begin
    stage_t st;
    logic   busy;
    st               = '{ph: PH_IDLE, cnt: delay_count};
    busy             = 1'b1;
    core_good_next   = core_good;
    hub_ok_next      = hub_ok;
    system_ok_next   = system_ok;
    ev_next          = EV_NONE;

    case (phase)
      PH_CORE, PH_READY, PH_HUB, PH_SYS: st.ph = phase;
      default:                           st.ph = PH_IDLE;
    endcase

    if (st.ph == PH_IDLE) begin
      if (!pg) begin
        core_good_next = 1'b0;
        hub_ok_next    = 1'b0;
        system_ok_next = 1'b0;
        busy           = 1'b0;
      end else begin
        st = pick_stage(core_good_next, hub_ok_next, system_ok_next, cfg);
        if (st.ph == PH_IDLE) busy = 1'b0;
      end
    end

    if (busy && st.ph == PH_CORE) begin
      if (st.cnt != '0) begin
        st.cnt = st.cnt - DELAY_W'(1);
        busy   = 1'b0;
      end else begin
        core_good_next = 1'b1;
        st = pick_stage(core_good_next, hub_ok_next, system_ok_next, cfg);
        if (st.ph == PH_IDLE) busy = 1'b0;
      end
    end

    if (busy && st.ph == PH_READY) begin
      if (st.cnt == '0) begin
        core_good_next = 1'b0;
        hub_ok_next    = 1'b0;
        system_ok_next = 1'b0;
        ev_next        = EV_TIMEOUT;
        st.ph          = PH_IDLE;
        busy           = 1'b0;
      end else if (rdy) begin
        st.ph  = PH_HUB;
        st.cnt = cfg.second_ok_delay;
      end else begin
        st.cnt = st.cnt - DELAY_W'(1);
        busy   = 1'b0;
      end
    end

    if (busy && st.ph == PH_HUB) begin
      if (st.cnt != '0) begin
        st.cnt = st.cnt - DELAY_W'(1);
        busy   = 1'b0;
      end else begin
        hub_ok_next = 1'b1;
        st = pick_stage(core_good_next, hub_ok_next, system_ok_next, cfg);
        if (st.ph == PH_IDLE) busy = 1'b0;
      end
    end

    if (busy && st.ph == PH_SYS) begin
      if (st.cnt != '0) begin
        st.cnt = st.cnt - DELAY_W'(1);
      end else begin
        // power-good must still be high at the end of the final delay
        if (!pg) begin
          core_good_next = 1'b0;
          hub_ok_next    = 1'b0;
          system_ok_next = 1'b0;
          ev_next        = EV_POWER_LOST;
        end else begin
          system_ok_next = 1'b1;
        end
        st.ph = PH_IDLE;
      end
    end

    phase_next       = st.ph;
    delay_count_next = st.cnt;
  end

  always_comb begin
    result.core_good = core_good_next;
    result.hub_ok    = hub_ok_next;
    result.system_ok = system_ok_next;
    result.shutdown  = ev_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      delay_count <= '0;
      core_good   <= 1'b0;
      hub_ok      <= 1'b0;
      system_ok   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      delay_count <= delay_count_next;
      core_good   <= core_good_next;
      hub_ok      <= hub_ok_next;
      system_ok   <= system_ok_next;
    end
  end

  a_order_sys: assert property (@(posedge clk) disable iff (rst)
    system_ok |-> (hub_ok && core_good))
    else $error("system ok high without hub and core");

  a_order_hub: assert property (@(posedge clk) disable iff (rst)
    hub_ok |-> core_good)
    else $error("hub ok high without core good");

  a_late_phase_core: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READY || phase == PH_HUB || phase == PH_SYS) |-> core_good)
    else $error("past core stage with core good low");

  a_shutdown_drops: assert property (@(posedge clk) disable iff (rst)
    (step && ev_next != EV_NONE) |=>
      (phase == PH_IDLE && !core_good && !hub_ok && !system_ok))
    else $error("shutdown did not drop outputs and go idle");

  a_hold_no_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(phase) && $stable(delay_count)))
    else $error("sequencer state moved without a tick");

endmodule

[hw/rtl/platform_power_good_sequencer_unit.sv]
// Top level of the platform power-good sequencer: input register, sequencer
// core, result register. Depends on ppgs_pkg, ppgs_cfg_regs and ppgs_core.

// One input transfer per millisecond tick gives exactly one result transfer.
// The block accepts one tick every clock cycle unless the result side stalls;
// a tick's result passes through the input register and then the result
// register, with all per-tick sequencing, including any chain of zero-length
// delays, done combinationally between those two registers.
// Backpressure on the result side stalls both registers. Configuration
// writes are always accepted and must be issued only with no tick in
// flight; indexes beyond the four registers are ignored.
module platform_power_good_sequencer_unit
  import ppgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   all_power_good,
  input  logic                   regulator_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   core_power_good,
  output logic                   hub_power_ok,
  output logic                   system_power_ok,
  output logic [1:0]             shutdown_event,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_data
);

  cfg_t    cfg;
  result_t result;
  logic    s1_valid;
  logic    s1_pg;
  logic    s1_rdy;
  logic    advance;
  logic    step;

  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  ppgs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppgs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .pg     (s1_pg),
    .rdy    (s1_rdy),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pg  <= all_power_good;
      s1_rdy <= regulator_ready;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      core_power_good <= result.core_good;
      hub_power_ok    <= result.hub_ok;
      system_power_ok <= result.system_ok;
      shutdown_event  <= result.shutdown;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(shutdown_event)
                                   && $stable(system_power_ok)))
    else $error("stalled result changed");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_pg) && $stable(s1_rdy)))
    else $error("stalled input register changed");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (shutdown_event != 2'd3))
    else $error("invalid shutdown event code");

endmodule

[tb/sv/ppgs_checker.sv]
// Result checker for the platform power-good sequencer: models the per-tick
// sequencing, queues expected levels per input transfer and compares results.
// Depends on ppgs_pkg.
module power_sequence_checker
  import ppgs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   all_power_good,
  input  logic                   regulator_ready,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   core_power_good,
  input  logic                   hub_power_ok,
  input  logic                   system_power_ok,
  input  logic [1:0]             shutdown_event,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]     cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t               delays;
  phase_t             stage;
  logic [DELAY_W-1:0] stage_count;
  logic               core_on;
  logic               hub_on;
  logic               sys_on;
  result_t            levels_due[$];

  function automatic void drop_levels();
    core_on = 1'b0;
    hub_on  = 1'b0;
    sys_on  = 1'b0;
  endfunction

  // Load the stage of the first output that is still low.
  function automatic void pick_stage();
    if (!core_on) begin
      stage       = PH_CORE;
      stage_count = delays.first_good_delay;
    end else if (!hub_on) begin
      stage       = PH_READY;
      stage_count = delays.ready_timeout;
    end else if (!sys_on) begin
      stage       = PH_SYS;
      stage_count = delays.system_ok_delay;
    end else begin
      stage       = PH_IDLE;
      stage_count = '0;
    end
  endfunction

  // Advance one tick; zero-length delays chain within the same tick.
  function automatic result_t sequence_tick(input logic pg, input logic rdy);
    event_t  shut;
    logic    busy;
    result_t lv;
    shut = EV_NONE;
    busy = 1'b1;
    if (stage == PH_IDLE) begin
      if (!pg) begin
        drop_levels();
        busy = 1'b0;
      end else begin
        pick_stage();
        busy = (stage != PH_IDLE);
      end
    end
    while (busy) begin
      case (stage)
        PH_CORE, PH_HUB: begin
          if (stage_count != '0) begin
            stage_count = stage_count - DELAY_W'(1);
            busy = 1'b0;
          end else begin
            if (stage == PH_CORE) core_on = 1'b1;
            else hub_on = 1'b1;
            pick_stage();
            busy = (stage != PH_IDLE);
          end
        end
        PH_READY: begin
          // the tick that reaches the timeout does not look at ready
          if (stage_count == '0) begin
            drop_levels();
            shut  = EV_TIMEOUT;
            stage = PH_IDLE;
            busy  = 1'b0;
          end else if (rdy) begin
            stage       = PH_HUB;
            stage_count = delays.second_ok_delay;
          end else begin
            stage_count = stage_count - DELAY_W'(1);
            busy = 1'b0;
          end
        end
        PH_SYS: begin
          if (stage_count != '0) begin
            stage_count = stage_count - DELAY_W'(1);
          end else begin
            if (!pg) begin
              drop_levels();
              shut = EV_POWER_LOST;
            end else begin
              sys_on = 1'b1;
            end
            stage = PH_IDLE;
          end
          busy = 1'b0;
        end
        default: begin
          stage = PH_IDLE;
          busy  = 1'b0;
        end
      endcase
    end
    lv.core_good = core_on;
    lv.hub_ok    = hub_on;
    lv.system_ok = sys_on;
    lv.shutdown  = shut;
    return lv;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      delays      = '{FIRST_GOOD_DELAY_RST, SECOND_OK_DELAY_RST,
                      SYSTEM_OK_DELAY_RST, READY_TIMEOUT_RST};
      stage       = PH_IDLE;
      stage_count = '0;
      drop_levels();
      levels_due.delete();
      mismatches  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_GOOD_DELAY: delays.first_good_delay = cfg_data;
          REG_SECOND_OK_DELAY:  delays.second_ok_delay  = cfg_data;
          REG_SYSTEM_OK_DELAY:  delays.system_ok_delay  = cfg_data;
          REG_READY_TIMEOUT:    delays.ready_timeout    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.core_good = core_power_good;
        got.hub_ok    = hub_power_ok;
        got.system_ok = system_power_ok;
        got.shutdown  = event_t'(shutdown_event);
        if (levels_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer expected none, got %b%b%b event %0d", $time,
                   core_power_good, hub_power_ok, system_power_ok, shutdown_event);
        end else begin
          want = levels_due.pop_front();
          check_field("core_power_good", want.core_good, got.core_good);
          check_field("hub_power_ok", want.hub_ok, got.hub_ok);
          check_field("system_power_ok", want.system_ok, got.system_ok);
          check_field("shutdown_event", want.shutdown, shutdown_event);
        end
      end
      if (in_valid && in_ready) levels_due.push_back(sequence_tick(all_power_good,
                                                                   regulator_ready));
    end
    outstanding <= levels_due.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the power-good sequencer testbench: clock, reset, register setup,
// tick and result-side stimulus, watchdog and verdict.
// Depends on ppgs_pkg, platform_power_good_sequencer_unit and power_sequence_checker.
module testbench
  import ppgs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int STEADY_FIRST_ITEM = 1000;
  localparam int STEADY_LAST_ITEM = 1300;
  localparam int HOLD_START_ITEM = 1500;
  localparam int HOLD_CYCLES = 300;

  // bit 1 is power good, bit 0 is regulator ready
  localparam logic [1:0] OPENING_TICKS [22] = '{
    2'b00, 2'b11, 2'b01, 2'b10, 2'b10, 2'b10, 2'b11, 2'b00, 2'b10, 2'b10, 2'b10,
    2'b11, 2'b10, 2'b11, 2'b10, 2'b10, 2'b01, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   all_power_good = 1'b0;
  logic                   regulator_ready = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   core_power_good;
  logic                   hub_power_ok;
  logic                   system_power_ok;
  logic [1:0]             shutdown_event;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int items_sent = 0;
  int fg, sd, sy, rt;

  always #4 clk = ~clk;

  platform_power_good_sequencer_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .all_power_good  (all_power_good),
    .regulator_ready (regulator_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .core_power_good (core_power_good),
    .hub_power_ok    (hub_power_ok),
    .system_power_ok (system_power_ok),
    .shutdown_event  (shutdown_event),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  power_sequence_checker sequence_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .all_power_good  (all_power_good),
    .regulator_ready (regulator_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .core_power_good (core_power_good),
    .hub_power_ok    (hub_power_ok),
    .system_power_ok (system_power_ok),
    .shutdown_event  (shutdown_event),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, a steady window matching the tick side's,
  // and one long hold-off while ticks keep coming so the block backs up.
  initial begin : result_side
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_START_ITEM && in_valid) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (items_sent >= STEADY_FIRST_ITEM && items_sent < STEADY_LAST_ITEM) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DELAY_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four delays plus one write to an unused index.
  task automatic program_delays(input int first, input int second, input int sys,
                                input int tmo);
    fg = first;
    sd = second;
    sy = sys;
    rt = tmo;
    write_reg(REG_FIRST_GOOD_DELAY, first);
    write_reg(REG_SECOND_OK_DELAY, second);
    write_reg(CFG_INDEX_W'($urandom_range(4, 15)), $urandom_range(0, 255));
    write_reg(REG_SYSTEM_OK_DELAY, sys);
    write_reg(REG_READY_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic pg, input logic rdy);
    while (!(items_sent >= STEADY_FIRST_ITEM && items_sent < STEADY_LAST_ITEM) &&
           $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    all_power_good  <= pg;
    regulator_ready <= rdy;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait out every result before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One bring-up from idle with all outputs low; power good is held high
  // wherever the sequencer looks at it, ready arrives at a chosen wait tick
  // or never, and power may fail on the last tick of the system delay.
  task automatic power_episode(input bit want_ready);
    int   ready_tick;
    int   last;
    int   t;
    bit   ready_seen;
    bit   lose;
    bit   noisy_pg;
    logic pg;
    logic rdy;
    ready_seen = want_ready && rt > 0;
    noisy_pg   = ($urandom_range(0, 99) < 30);
    lose       = ($urandom_range(0, 99) < 30);
    if (ready_seen) begin
      ready_tick = fg + $urandom_range(0, rt - 1);
      last       = ready_tick + sd + sy;
    end else begin
      ready_tick = -1;
      last       = fg + rt;
    end
    for (t = 0; t <= last; t++) begin
      pg = (t == 0) ? 1'b1 : (noisy_pg ? 1'($urandom) : 1'b1);
      if (ready_seen && t == last && t > 0) pg = !lose;
      if (t < fg || (ready_seen && t > ready_tick)) rdy = 1'($urandom);
      else if (t == ready_tick) rdy = 1'b1;
      else if (!ready_seen && t == last) rdy = 1'($urandom);
      else rdy = 1'b0;
      send_tick(pg, rdy);
    end
    if (ready_seen && !lose) repeat ($urandom_range(0, 3)) send_tick(1'b1, 1'($urandom));
    repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'($urandom));
  endtask

  // Random ticks, then enough low ticks to run out any sequence they began.
  task automatic noise_burst();
    int flush;
    repeat ($urandom_range(1, 20)) send_tick(1'($urandom), 1'($urandom));
    flush = ((fg + rt > sd + sy) ? fg + rt : sd + sy) + 2;
    repeat (flush) send_tick(1'b0, 1'b0);
  endtask

  task automatic run_phase(input int budget);
    int stop;
    int pick;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) power_episode(1'b1);
      else if (pick < 80) power_episode(1'b0);
      else noise_burst();
    end
    drain();
  endtask

  initial begin : stimulus
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_delays(1, 1, 2, 2);
    for (i = 0; i < $size(OPENING_TICKS); i++)
      send_tick(OPENING_TICKS[i][1], OPENING_TICKS[i][0]);
    drain();

    program_delays(0, 0, 0, 0);
    run_phase(120);
    program_delays(0, 0, 0, 1);
    run_phase(120);
    program_delays(FIRST_GOOD_DELAY_RST, SECOND_OK_DELAY_RST, SYSTEM_OK_DELAY_RST,
                   READY_TIMEOUT_RST);
    run_phase(350);
    program_delays(255, 1, 2, 3);
    run_phase(250);
    program_delays(1, 255, 255, 255);
    run_phase(500);
    repeat (3) begin
      program_delays($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 20),
                     $urandom_range(1, 12));
      run_phase(170);
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[platform_power_good_sequencer_unit.f]
hw/rtl/ppgs_pkg.sv
hw/rtl/ppgs_cfg_regs.sv
hw/rtl/ppgs_core.sv
hw/rtl/platform_power_good_sequencer_unit.sv
tb/sv/ppgs_checker.sv
tb/sv/testbench.sv
